// ===== design/btpc_pkg.sv =====
package btpc_pkg;

   // register file
   localparam int unsigned CsrDataBits = 48;
   localparam int unsigned CsrIdxBits  = 2;

   typedef enum logic [CsrIdxBits-1:0] {
      REG_TEMP    = 2'd0,
      REG_PRESS_A = 2'd1,
      REG_PRESS_B = 2'd2,
      REG_PRESS_C = 2'd3
   } reg_index_type;

   // long division: 64-bit dividend magnitude, 31-bit divisor magnitude
   localparam int unsigned NumBits = 64;
   localparam int unsigned DenBits = 31;

   // fixed constants of the compensation formulas
   localparam logic signed [63:0] PressBias   = 64'sh0000_8000_0000_0000;
   localparam logic        [20:0] PressFull   = 21'd1048576;
   localparam logic signed [25:0] FineOffset  = 26'sd128000;
   localparam logic signed [15:0] TempMax     = 16'sd32767;
   localparam logic signed [15:0] TempMin     = -16'sd32768;

   // data that rides along with the pressure through the divider
   typedef struct packed {
      logic signed [15:0] temp;
      logic               zero;
   } side_type;

endpackage

// ===== design/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation.
// The req channel takes one raw 20-bit temperature and one raw 20-bit
// pressure conversion per transfer; the rsp channel returns, for each, the
// temperature in 0.01 degC (saturated to 16 bits), the pressure in Pa with
// 8 fraction bits, and divide_error when the pressure divisor was zero
// (pressure then reads 0).
// Trimming coefficients sit in four 48-bit registers written through the
// csr port (index 0 temperature, 1..3 pressure); write them only while no
// transfer is in flight.
// From a req transfer to rsp_valid the data passes 11 arithmetic
// stages, 64 stages of restoring division (one quotient bit each), 5
// post-division stages and the output register. Throughput is one item
// per cycle while the pipeline is not frozen.
// Reset clears all valid bits and the coefficient registers.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated.
module baro_temp_pressure_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [19:0]                          req_raw_temperature,
   input  logic [19:0]                          req_raw_pressure,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [15:0]                   rsp_temperature_centi,
   output logic [31:0]                          rsp_pressure_q8,
   output logic                                 rsp_divide_error,
   input  logic                                 csr_write_enable,
   input  logic [btpc_pkg::CsrIdxBits-1:0]      csr_index,
   input  logic [btpc_pkg::CsrDataBits-1:0]     csr_write_data
);

   localparam int unsigned N = btpc_pkg::NumBits;
   localparam int unsigned D = btpc_pkg::DenBits;

   logic advance;

   // coefficient registers
   logic [btpc_pkg::CsrDataBits-1:0] temp_coeffs_ff;
   logic [btpc_pkg::CsrDataBits-1:0] press_a_ff;
   logic [btpc_pkg::CsrDataBits-1:0] press_b_ff;
   logic [btpc_pkg::CsrDataBits-1:0] press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_c_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (btpc_pkg::reg_index_type'(csr_index))
            btpc_pkg::REG_TEMP:    temp_coeffs_ff <= csr_write_data;
            btpc_pkg::REG_PRESS_A: press_a_ff     <= csr_write_data;
            btpc_pkg::REG_PRESS_B: press_b_ff     <= csr_write_data;
            btpc_pkg::REG_PRESS_C: press_c_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // coefficient fields
   logic        [15:0] t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_coeffs_ff[15:0];
   assign t2 = $signed(temp_coeffs_ff[31:16]);
   assign t3 = $signed(temp_coeffs_ff[47:32]);
   assign p1 = press_a_ff[15:0];
   assign p2 = $signed(press_a_ff[31:16]);
   assign p3 = $signed(press_a_ff[47:32]);
   assign p4 = $signed(press_b_ff[15:0]);
   assign p5 = $signed(press_b_ff[31:16]);
   assign p6 = $signed(press_b_ff[47:32]);
   assign p7 = $signed(press_c_ff[15:0]);
   assign p8 = $signed(press_c_ff[31:16]);
   assign p9 = $signed(press_c_ff[47:32]);

   // the whole pipeline moves unless a result waits on a stalled receiver
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: temperature differences
   logic               s1_valid_ff;
   logic signed [18:0] s1_x_ff, s1_x_in;
   logic signed [17:0] s1_d_ff, s1_d_in;
   logic        [19:0] s1_adcp_ff;

   assign s1_x_in = $signed({2'b00, req_raw_temperature[19:3]})
                  - $signed({2'b00, t1, 1'b0});
   assign s1_d_in = $signed({2'b00, req_raw_temperature[19:4]})
                  - $signed({2'b00, t1});

   // stage 2: first temperature products
   logic               s2_valid_ff;
   logic signed [34:0] s2_ma_ff, s2_ma_in;
   logic signed [35:0] s2_dd_ff, s2_dd_in;
   logic        [19:0] s2_adcp_ff;

   assign s2_ma_in = s1_x_ff * t2;
   assign s2_dd_in = s1_d_ff * s1_d_ff;

   // stage 3: scale and multiply by t3
   logic               s3_valid_ff;
   logic signed [23:0] s3_a_ff, s3_a_in;
   logic signed [21:0] s3_dsh;
   logic signed [37:0] s3_bm_ff, s3_bm_in;
   logic        [19:0] s3_adcp_ff;

   assign s3_a_in  = 24'(s2_ma_ff >>> 11);
   assign s3_dsh   = 22'(s2_dd_ff >>> 12);
   assign s3_bm_in = s3_dsh * t3;

   // stage 4: fine temperature scaled by 7/8
   logic               s4_valid_ff;
   logic signed [23:0] s4_b;
   logic signed [24:0] s4_sum;
   logic signed [27:0] s4_prod;
   logic signed [24:0] s4_fine_ff, s4_fine_in;
   logic        [19:0] s4_adcp_ff;

   assign s4_b       = 24'(s3_bm_ff >>> 14);
   assign s4_sum     = s3_a_ff + s4_b;
   assign s4_prod    = s4_sum * 4'sd7;
   assign s4_fine_in = 25'(s4_prod >>> 3);

   // stage 5: temperature output and pressure offset
   logic               s5_valid_ff;
   logic signed [27:0] s5_t5;
   logic signed [19:0] s5_tsh;
   btpc_pkg::side_type s5_side_ff, s5_side_in;
   logic signed [25:0] s5_pa_ff, s5_pa_in;
   logic        [19:0] s5_adcp_ff;

   assign s5_t5  = s4_fine_ff * 4'sd5 + 28'sd128;
   assign s5_tsh = 20'(s5_t5 >>> 8);

   always_comb begin
      if (s5_tsh > 20'sd32767) begin
         s5_side_in.temp = btpc_pkg::TempMax;
      end else if (s5_tsh < -20'sd32768) begin
         s5_side_in.temp = btpc_pkg::TempMin;
      end else begin
         s5_side_in.temp = 16'(s5_tsh);
      end
      s5_side_in.zero = 1'b0;
   end

   assign s5_pa_in = s4_fine_ff - btpc_pkg::FineOffset;

   // stage 6: square and linear pressure products
   logic               s6_valid_ff;
   btpc_pkg::side_type s6_side_ff;
   logic signed [51:0] s6_aa_ff, s6_aa_in;
   logic signed [41:0] s6_ap5_ff, s6_ap5_in;
   logic signed [41:0] s6_ap2_ff, s6_ap2_in;
   logic        [19:0] s6_adcp_ff;

   assign s6_aa_in  = s5_pa_ff * s5_pa_ff;
   assign s6_ap5_in = s5_pa_ff * p5;
   assign s6_ap2_in = s5_pa_ff * p2;

   // stage 7: square times p6 and p3, wrapping
   logic               s7_valid_ff;
   btpc_pkg::side_type s7_side_ff;
   logic signed [63:0] s7_bp6_ff, s7_bp6_in;
   logic signed [63:0] s7_ap3_ff, s7_ap3_in;
   logic signed [41:0] s7_ap5_ff;
   logic signed [41:0] s7_ap2_ff;
   logic        [19:0] s7_adcp_ff;

   assign s7_bp6_in = s6_aa_ff * p6;
   assign s7_ap3_in = s6_aa_ff * p3;

   // stage 8: sums for the offset and divisor terms
   logic               s8_valid_ff;
   btpc_pkg::side_type s8_side_ff;
   logic signed [63:0] s8_ap5_x, s8_ap2_x, s8_p4_x;
   logic signed [63:0] s8_b_ff, s8_b_in;
   logic signed [63:0] s8_acc_ff, s8_acc_in;
   logic        [19:0] s8_adcp_ff;

   assign s8_ap5_x  = s7_ap5_ff;
   assign s8_ap2_x  = s7_ap2_ff;
   assign s8_p4_x   = p4;
   assign s8_b_in   = s7_bp6_ff + (s8_ap5_x <<< 17) + (s8_p4_x <<< 35);
   assign s8_acc_in = (s7_ap3_ff >>> 8) + (s8_ap2_x <<< 12) + btpc_pkg::PressBias;

   // stage 9: divisor product and numerator base
   logic               s9_valid_ff;
   btpc_pkg::side_type s9_side_ff;
   logic        [20:0] s9_nbase;
   logic signed [63:0] s9_m_ff, s9_m_in;
   logic signed [63:0] s9_nb_ff, s9_nb_in;

   assign s9_m_in  = s8_acc_ff * $signed({1'b0, p1});
   assign s9_nbase = btpc_pkg::PressFull - {1'b0, s8_adcp_ff};
   assign s9_nb_in = $signed({12'b0, s9_nbase, 31'b0}) - s8_b_ff;

   // stage 10: divisor and numerator
   logic               s10_valid_ff;
   btpc_pkg::side_type s10_side_ff;
   logic signed [D-1:0] s10_dv_ff, s10_dv_in;
   logic signed [63:0] s10_num_ff, s10_num_in;

   assign s10_dv_in  = D'(s9_m_ff >>> 33);
   assign s10_num_in = s9_nb_ff * 13'sd3125;

   // stage 11: magnitudes, quotient sign and zero-divisor flag
   logic               s11_valid_ff;
   btpc_pkg::side_type s11_side_ff, s11_side_in;
   logic [N-1:0]       s11_nmag_ff, s11_nmag_in;
   logic [D-1:0]       s11_dmag_ff, s11_dmag_in;
   logic               s11_neg_ff, s11_neg_in;

   assign s11_nmag_in = s10_num_ff[N-1] ? (~s10_num_ff + 64'd1) : s10_num_ff;
   assign s11_dmag_in = s10_dv_ff[D-1] ? (~s10_dv_ff + 31'd1) : s10_dv_ff;
   assign s11_neg_in  = s10_num_ff[N-1] ^ s10_dv_ff[D-1];

   always_comb begin
      s11_side_in      = s10_side_ff;
      s11_side_in.zero = (s10_dv_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff     <= s1_x_in;
         s1_d_ff     <= s1_d_in;
         s1_adcp_ff  <= req_raw_pressure;
         s2_ma_ff    <= s2_ma_in;
         s2_dd_ff    <= s2_dd_in;
         s2_adcp_ff  <= s1_adcp_ff;
         s3_a_ff     <= s3_a_in;
         s3_bm_ff    <= s3_bm_in;
         s3_adcp_ff  <= s2_adcp_ff;
         s4_fine_ff  <= s4_fine_in;
         s4_adcp_ff  <= s3_adcp_ff;
         s5_side_ff  <= s5_side_in;
         s5_pa_ff    <= s5_pa_in;
         s5_adcp_ff  <= s4_adcp_ff;
         s6_side_ff  <= s5_side_ff;
         s6_aa_ff    <= s6_aa_in;
         s6_ap5_ff   <= s6_ap5_in;
         s6_ap2_ff   <= s6_ap2_in;
         s6_adcp_ff  <= s5_adcp_ff;
         s7_side_ff  <= s6_side_ff;
         s7_bp6_ff   <= s7_bp6_in;
         s7_ap3_ff   <= s7_ap3_in;
         s7_ap5_ff   <= s6_ap5_ff;
         s7_ap2_ff   <= s6_ap2_ff;
         s7_adcp_ff  <= s6_adcp_ff;
         s8_side_ff  <= s7_side_ff;
         s8_b_ff     <= s8_b_in;
         s8_acc_ff   <= s8_acc_in;
         s8_adcp_ff  <= s7_adcp_ff;
         s9_side_ff  <= s8_side_ff;
         s9_m_ff     <= s9_m_in;
         s9_nb_ff    <= s9_nb_in;
         s10_side_ff <= s9_side_ff;
         s10_dv_ff   <= s10_dv_in;
         s10_num_ff  <= s10_num_in;
         s11_side_ff <= s11_side_in;
         s11_nmag_ff <= s11_nmag_in;
         s11_dmag_ff <= s11_dmag_in;
         s11_neg_ff  <= s11_neg_in;
      end
   end

   // long division of magnitudes
   logic               dv_valid;
   logic [N-1:0]       dv_quot;
   logic               dv_neg;
   btpc_pkg::side_type dv_side;

   btpc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s11_valid_ff),
      .in_num    (s11_nmag_ff),
      .in_den    (s11_dmag_ff),
      .in_neg    (s11_neg_ff),
      .in_side   (s11_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_neg   (dv_neg),
      .out_side  (dv_side)
   );

   // post stage 0: signed quotient
   logic               q0_valid_ff;
   btpc_pkg::side_type q0_side_ff;
   logic signed [63:0] q0_q_ff, q0_q_in;

   assign q0_q_in = $signed(dv_neg ? (~dv_quot + 64'd1) : dv_quot);

   // post stage 1: shifted quotient and single products
   logic               q1_valid_ff;
   btpc_pkg::side_type q1_side_ff;
   logic signed [63:0] q1_q_ff;
   logic signed [50:0] q1_d_ff, q1_d_in;
   logic signed [63:0] q1_pd9_ff, q1_pd9_in;
   logic signed [63:0] q1_bp8_ff, q1_bp8_in;

   assign q1_d_in   = 51'(q0_q_ff >>> 13);
   assign q1_pd9_in = p9 * q1_d_in;
   assign q1_bp8_in = p8 * q0_q_ff;

   // post stage 2: partial products of the wide square term
   logic               q2_valid_ff;
   btpc_pkg::side_type q2_side_ff;
   logic signed [63:0] q2_q_ff;
   logic signed [63:0] q2_y;
   logic        [63:0] q2_ll_ff, q2_ll_in;
   logic        [31:0] q2_cross_ff, q2_cross_in;
   logic signed [63:0] q2_b8_ff, q2_b8_in;

   assign q2_y        = q1_d_ff;
   assign q2_ll_in    = q1_pd9_ff[31:0] * q2_y[31:0];
   assign q2_cross_in = q1_pd9_ff[63:32] * q2_y[31:0] + q1_pd9_ff[31:0] * q2_y[63:32];
   assign q2_b8_in    = q1_bp8_ff >>> 19;

   // post stage 3: assemble the wrapped product
   logic               q3_valid_ff;
   btpc_pkg::side_type q3_side_ff;
   logic signed [63:0] q3_q_ff;
   logic signed [63:0] q3_prod_ff, q3_prod_in;
   logic signed [63:0] q3_b8_ff;

   assign q3_prod_in = $signed(q2_ll_ff + {q2_cross_ff, 32'b0});

   // post stage 4: correction sum
   logic               q4_valid_ff;
   btpc_pkg::side_type q4_side_ff;
   logic signed [63:0] q4_s_ff, q4_s_in;

   assign q4_s_in = q3_q_ff + (q3_prod_ff >>> 25) + q3_b8_ff;

   // output register
   logic signed [63:0] out_p7_x;
   logic signed [63:0] out_sum;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_temp_ff;
   logic [31:0]        rsp_press_ff, rsp_press_in;
   logic               rsp_err_ff;

   assign out_p7_x     = p7;
   assign out_sum      = (q4_s_ff >>> 8) + (out_p7_x <<< 4);
   assign rsp_press_in = q4_side_ff.zero ? 32'd0 : out_sum[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         q0_valid_ff  <= 1'b0;
         q1_valid_ff  <= 1'b0;
         q2_valid_ff  <= 1'b0;
         q3_valid_ff  <= 1'b0;
         q4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         q0_valid_ff  <= dv_valid;
         q1_valid_ff  <= q0_valid_ff;
         q2_valid_ff  <= q1_valid_ff;
         q3_valid_ff  <= q2_valid_ff;
         q4_valid_ff  <= q3_valid_ff;
         rsp_valid_ff <= q4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q0_side_ff   <= dv_side;
         q0_q_ff      <= q0_q_in;
         q1_side_ff   <= q0_side_ff;
         q1_q_ff      <= q0_q_ff;
         q1_d_ff      <= q1_d_in;
         q1_pd9_ff    <= q1_pd9_in;
         q1_bp8_ff    <= q1_bp8_in;
         q2_side_ff   <= q1_side_ff;
         q2_q_ff      <= q1_q_ff;
         q2_ll_ff     <= q2_ll_in;
         q2_cross_ff  <= q2_cross_in;
         q2_b8_ff     <= q2_b8_in;
         q3_side_ff   <= q2_side_ff;
         q3_q_ff      <= q2_q_ff;
         q3_prod_ff   <= q3_prod_in;
         q3_b8_ff     <= q2_b8_ff;
         q4_side_ff   <= q3_side_ff;
         q4_s_ff      <= q4_s_in;
         rsp_temp_ff  <= q4_side_ff.temp;
         rsp_press_ff <= rsp_press_in;
         rsp_err_ff   <= q4_side_ff.zero;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_pressure_q8       = rsp_press_ff;
   assign rsp_divide_error      = rsp_err_ff;

endmodule

// ===== design/btpc_divider.sv =====
module btpc_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [btpc_pkg::NumBits-1:0]        in_num,
   input  logic [btpc_pkg::DenBits-1:0]        in_den,
   input  logic                                in_neg,
   input  btpc_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic [btpc_pkg::NumBits-1:0]        out_quot,
   output logic                                out_neg,
   output btpc_pkg::side_type                  out_side
);

   localparam int unsigned N = btpc_pkg::NumBits;
   localparam int unsigned D = btpc_pkg::DenBits;

   logic               vld_ff  [N];
   logic [D-1:0]       rem_ff  [N];
   logic [N-1:0]       work_ff [N];
   logic [D-1:0]       den_ff  [N];
   logic               neg_ff  [N];
   btpc_pkg::side_type side_ff [N];

   // one quotient bit per stage, dividend bits shift out the top of work
   // while quotient bits shift in at the bottom
   for (genvar k = 0; k < N; k++) begin : g_step
      logic               src_vld;
      logic [D-1:0]       src_rem;
      logic [D-1:0]       src_den;
      logic [N-1:0]       src_work;
      logic               src_neg;
      btpc_pkg::side_type src_side;
      logic [D:0]         trial;
      logic               fits;
      logic [D-1:0]       rem_in;
      logic [N-1:0]       work_in;

      if (k == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rem  = '0;
         assign src_den  = in_den;
         assign src_work = in_num;
         assign src_neg  = in_neg;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_work = work_ff[k-1];
         assign src_neg  = neg_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      // trial subtract
      assign trial   = {src_rem, src_work[N-1]};
      assign fits    = trial >= {1'b0, src_den};
      assign rem_in  = fits ? D'(trial - {1'b0, src_den}) : trial[D-1:0];
      assign work_in = {src_work[N-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= src_vld;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            work_ff[k] <= work_in;
            den_ff[k]  <= src_den;
            neg_ff[k]  <= src_neg;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quot  = work_ff[N-1];
   assign out_neg   = neg_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule
